// File: sv/sfrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// sfrr_pkg: types and constants of the serial flash read responder
// no dependencies; imported by spi_flash_read_responder

package sfrr_pkg;

	// byte store geometry
	localparam int unsigned STORE_DEPTH = 65536;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	// widths of the configuration registers and the read pointer
	localparam int unsigned BASE_W  = 24;
	localparam int unsigned LEN_W   = 17;
	localparam int unsigned ADDR_W  = 25;   // holds base + length
	localparam int unsigned SHIFT_W = 31;   // top bit of the shifted word is never stored
	localparam int unsigned EDGE_W  = 8;

	// command codes
	localparam logic [7:0] CMD_RELEASE = 8'hAB;
	localparam logic [7:0] CMD_READ    = 8'h03;

	// edge counts that complete a command
	localparam logic [EDGE_W-1:0] EDGES_RELEASE = EDGE_W'(7);
	localparam logic [EDGE_W-1:0] EDGES_READ    = EDGE_W'(31);

	// beat kinds
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// register indexes
	localparam logic CFG_FLASH_BASE   = 1'b0;
	localparam logic CFG_FLASH_LENGTH = 1'b1;

	typedef enum logic [5:0] {
		PH_IDLE        = 6'b000001,
		PH_SEL_PD      = 6'b000010,
		PH_NEED_DESEL  = 6'b000100,
		PH_DESEL_UP    = 6'b001000,
		PH_SEL_UP      = 6'b010000,
		PH_READING     = 6'b100000
	} phase_t;

endpackage : sfrr_pkg

`default_nettype wire

// File: sv/spi_flash_read_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// spi_flash_read_responder: device side of a serial flash, read command 0x03
// depends on sfrr_pkg
//
// usage
//  - input channel (in_valid / in_stall): one beat per rising spi clock edge
//    (op = 0, with cs and copi) or one byte load into the store (op = 1,
//    load_index / load_data)
//  - output channel (out_valid / out_stall): one beat per input beat, carrying
//    the cipo bit driven after that edge (0 for loads and outside reads)
//  - power-up: release command 0xab, deselect, reselect; then 0x03 plus a
//    24-bit address starts a read, first bit out on the edge closing the address
//  - configuration: cfg_we writes flash_base / flash_length; the user writes
//    only while idle, as the block does not enforce it
// timing
//  - input beat to output beat: edge state is updated and the store read issued
//    at acceptance, the store data register is stage 1, the output register follows
//  - throughput one beat per cycle while in_stall is low; the single-port byte
//    store (one access per beat, read or write) sets that figure
// reset and stall
//  - reset puts the device powered down with counters cleared; the store keeps
//    whatever it holds and is undefined until loaded
//  - a stalled output holds its beat; stage 1 keeps taking beats until both
//    it and the output register are full, then in_stall rises

module spi_flash_read_responder
	import sfrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [BASE_W-1:0] cfg_wdata,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              op,
	input  wire logic              cs,
	input  wire logic              copi,
	input  wire logic [15:0]       load_index,
	input  wire logic [7:0]        load_data,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   cipo
);

	// configuration, plus the window limit kept alongside
	logic [BASE_W-1:0]  flash_base_q;
	logic [LEN_W-1:0]   flash_length_q;
	logic [ADDR_W-1:0]  flash_lim_q;

	// edge state
	phase_t             phase_q, phase_d;
	logic [SHIFT_W-1:0] shift_q;
	logic [EDGE_W-1:0]  edge_cnt_q;
	logic [ADDR_W-1:0]  read_addr_q;
	logic [2:0]         bit_pos_q;

	// byte store
	logic [7:0]         store_mem [STORE_DEPTH];

	// stage 1 and output register
	logic               valid_s1;
	logic               hit_s1;
	logic [2:0]         bit_pos_s1;
	logic [7:0]         rdata_s1;
	logic               out_valid_q;
	logic               cipo_q;

	logic               accept;
	logic               s1_adv;
	logic               is_edge;
	logic [31:0]        nxt;
	logic               start_read;
	logic               emit;
	logic [ADDR_W-1:0]  cur_addr;
	logic [ADDR_W-1:0]  offset;
	logic               in_window;
	logic               store_hit;
	logic               rd_en;
	logic               cipo_s1;

	// handshake
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign is_edge  = (op == OP_EDGE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q   <= '0;
			flash_length_q <= '0;
			flash_lim_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLASH_BASE: begin
					flash_base_q <= cfg_wdata;
					flash_lim_q  <= ADDR_W'(cfg_wdata) + ADDR_W'(flash_length_q);
				end
				CFG_FLASH_LENGTH: begin
					flash_length_q <= cfg_wdata[LEN_W-1:0];
					flash_lim_q    <= ADDR_W'(flash_base_q) + ADDR_W'(cfg_wdata[LEN_W-1:0]);
				end
			endcase
		end
	end

	// word as it stands after shifting in this edge's bit
	assign nxt = {shift_q, copi};

	assign start_read = (phase_q == PH_SEL_UP) && (edge_cnt_q == EDGES_READ) &&
	                    (nxt[31:24] == CMD_READ);
	assign emit       = start_read || (phase_q == PH_READING);

	// a fresh read takes its address from the shifted word
	assign cur_addr  = start_read ? ADDR_W'(nxt[23:0]) : read_addr_q;
	assign in_window = (cur_addr >= ADDR_W'(flash_base_q)) && (cur_addr < flash_lim_q);
	assign offset    = cur_addr - ADDR_W'(flash_base_q);
	assign store_hit = (32'(offset) < STORE_DEPTH);
	assign rd_en     = accept && is_edge && emit && in_window && store_hit;

	// phase sequencing
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SEL_PD: begin
				if (edge_cnt_q == EDGES_RELEASE && nxt[7:0] == CMD_RELEASE)
					phase_d = PH_NEED_DESEL;
			end
			PH_NEED_DESEL: begin
				if (!cs)
					phase_d = PH_DESEL_UP;
			end
			PH_DESEL_UP: begin
				if (cs)
					phase_d = PH_SEL_UP;
			end
			PH_SEL_UP: begin
				// deselect on the closing edge still sends its bit, then drops out
				if (start_read)
					phase_d = cs ? PH_READING : PH_IDLE;
			end
			PH_READING: begin
				if (!cs)
					phase_d = PH_IDLE;
			end
			default: begin
				phase_d = cs ? PH_SEL_PD : PH_IDLE;
			end
		endcase
	end

	// edge state update, loads leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			edge_cnt_q  <= '0;
			read_addr_q <= '0;
			bit_pos_q   <= '0;
		end else if (accept && is_edge) begin
			phase_q <= phase_d;
			if (cs) begin
				shift_q    <= nxt[SHIFT_W-1:0];
				edge_cnt_q <= edge_cnt_q + EDGE_W'(1);
			end else begin
				edge_cnt_q <= '0;
			end
			// outside the window the bit index holds and the pointer keeps the current address
			if (emit) begin
				if (in_window) begin
					bit_pos_q   <= bit_pos_q + 3'd1;
					read_addr_q <= (bit_pos_q == 3'd7) ? cur_addr + ADDR_W'(1) : cur_addr;
				end else begin
					read_addr_q <= cur_addr;
				end
			end
		end
	end

	// byte store: one write or one read per beat, read data registered
	always_ff @(posedge clk) begin
		if (accept && !is_edge && (32'(load_index) < STORE_DEPTH))
			store_mem[load_index[STORE_AW-1:0]] <= load_data;
		if (rd_en)
			rdata_s1 <= store_mem[offset[STORE_AW-1:0]];
	end

	// stage 1 side information
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= is_edge && emit && in_window && store_hit;
			bit_pos_s1 <= bit_pos_q;
		end
	end

	// msb first
	assign cipo_s1 = hit_s1 && rdata_s1[~bit_pos_s1];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			cipo_q <= cipo_s1;
	end

	assign out_valid = out_valid_q;
	assign cipo      = cipo_q;

	// a stall only ever comes from both stages being full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	// load beats leave the edge state untouched
	a_load_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_LOAD) |=> ($stable(phase_q) && $stable(edge_cnt_q) &&
		                               $stable(bit_pos_q) && $stable(read_addr_q)))
		else $error("load beat changed edge state");

	// a deselected edge clears the edge count
	a_desel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_EDGE && !cs) |=> (edge_cnt_q == '0))
		else $error("edge count not cleared on deselect");

	// the bit index moves only on an accepted edge beat
	a_bitpos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && op == OP_EDGE) |=> $stable(bit_pos_q))
		else $error("bit index moved without an edge");

endmodule : spi_flash_read_responder

`default_nettype wire

// File: bench/spi_flash_read_responder_chk.sv
`timescale 1ns / 1ps
// spi_flash_read_responder_chk: watches both channels and the register port,
// predicts every cipo beat of the flash responder and compares in order
// depends on sfrr_pkg

module spi_flash_read_responder_chk
	import sfrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [BASE_W-1:0] cfg_wdata,

	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              op,
	input  wire logic              cs,
	input  wire logic              copi,
	input  wire logic [15:0]       load_index,
	input  wire logic [7:0]        load_data,

	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic              cipo,

	output int unsigned            fail_count,
	output int unsigned            pending
);

	// window registers as the device sees them
	logic [31:0] win_base;
	logic [31:0] win_len;

	// device state
	phase_t      dev_phase;
	logic [31:0] shift_q;
	logic [7:0]  edge_cnt;
	logic [31:0] rd_addr;
	logic [2:0]  bit_pos;
	bit   [7:0]  store_copy [STORE_DEPTH];

	bit          cipo_due [$];
	int unsigned err_cnt;

	// next bit of the current read; holds position outside the window
	function automatic bit read_bit();
		logic [31:0] off;
		logic [7:0]  data;
		bit          b;
		b = 1'b0;
		if (rd_addr >= win_base && rd_addr < win_base + win_len) begin
			off  = rd_addr - win_base;
			data = (off < STORE_DEPTH) ? store_copy[off[STORE_AW-1:0]] : 8'h00;
			b    = data[3'd7 - bit_pos];
			bit_pos = bit_pos + 3'd1;
			if (bit_pos == 3'd0)
				rd_addr = rd_addr + 32'd1;
		end
		return b;
	endfunction

	function automatic bit next_cipo(logic kind, logic sel, logic din,
	                                 logic [15:0] idx, logic [7:0] val);
		logic [31:0] nxt;
		bit          b;
		b = 1'b0;
		if (kind == OP_LOAD) begin
			store_copy[idx] = val;
			return 1'b0;
		end
		nxt = {shift_q[30:0], din};
		case (dev_phase)
			PH_SEL_PD: begin
				if (edge_cnt == EDGES_RELEASE && nxt[7:0] == CMD_RELEASE)
					dev_phase = PH_NEED_DESEL;
			end
			PH_NEED_DESEL: begin
				if (!sel)
					dev_phase = PH_DESEL_UP;
			end
			PH_DESEL_UP: begin
				if (sel)
					dev_phase = PH_SEL_UP;
			end
			PH_SEL_UP: begin
				if (edge_cnt == EDGES_READ && nxt[31:24] == CMD_READ) begin
					rd_addr   = {8'h00, nxt[23:0]};
					b         = read_bit();
					dev_phase = PH_READING;
					if (!sel)
						dev_phase = PH_IDLE;
				end
			end
			PH_READING: begin
				b = read_bit();
				if (!sel)
					dev_phase = PH_IDLE;
			end
			default: begin
				if (sel)
					dev_phase = PH_SEL_PD;
				else
					dev_phase = PH_IDLE;
			end
		endcase
		if (sel) begin
			shift_q  = nxt;
			edge_cnt = edge_cnt + 8'd1;
		end else begin
			edge_cnt = '0;
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			win_base  = '0;
			win_len   = '0;
			dev_phase = PH_IDLE;
			shift_q   = '0;
			edge_cnt  = '0;
			rd_addr   = '0;
			bit_pos   = '0;
			err_cnt   = 0;
			cipo_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (cipo_due.size() == 0) begin
					$error("cipo: no beat expected, actual %0d", cipo);
					err_cnt++;
				end else begin
					want = cipo_due.pop_front();
					if (cipo !== want) begin
						$error("cipo: expected %0d, actual %0d", want, cipo);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				cipo_due.push_back(next_cipo(op, cs, copi, load_index, load_data));
			if (cfg_we) begin
				if (cfg_index == CFG_FLASH_BASE)
					win_base = {8'h00, cfg_wdata};
				else
					win_len = {15'h0000, cfg_wdata[LEN_W-1:0]};
			end
		end
		fail_count <= err_cnt;
		pending    <= cipo_due.size();
	end

endmodule : spi_flash_read_responder_chk

// File: bench/spi_flash_read_responder_tb.sv
`timescale 1ns / 1ps
// spi_flash_read_responder_tb: stimulus and verdict for the flash read responder
// drives power-up, read and load sequences under several address windows;
// depends on sfrr_pkg, spi_flash_read_responder and spi_flash_read_responder_chk

module spi_flash_read_responder_tb;
	import sfrr_pkg::*;

	localparam int unsigned ITEMS       = 900;   // random beats, spread over the windows
	localparam int unsigned WINDOWS     = 6;
	localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int unsigned STALE_LIMIT = 5000;  // cycles without any beat moving
	localparam int unsigned SETTLE      = 8;     // settling time after the last expected beat
	localparam int unsigned MAX_SEL_RUN = 30;    // noise never reaches a full read command

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [BASE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic              cs;
	logic              copi;
	logic [15:0]       load_index;
	logic [7:0]        load_data;
	logic              out_valid;
	logic              out_stall;
	logic              cipo;

	int unsigned fail_count;
	int unsigned pending;

	// stimulus bookkeeping
	int unsigned beats_sent;
	int unsigned stim_mode;     // 0: sender light / receiver heavy, 1: swapped, 2: no idling
	int unsigned sel_run;       // consecutive selected edges just sent
	int unsigned stale;
	bit          hold_req;
	bit          hold_done;
	logic [31:0] cur_base;
	logic [31:0] cur_len;
	bit          written_map [STORE_DEPTH];

	spi_flash_read_responder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.cs         (cs),
		.copi       (copi),
		.load_index (load_index),
		.load_data  (load_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cipo       (cipo)
	);

	spi_flash_read_responder_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.cs         (cs),
		.copi       (copi),
		.load_index (load_index),
		.load_data  (load_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cipo       (cipo),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one input beat: optional idle cycles first, then hold until accepted
	task automatic put_beat(logic kind, logic sel, logic din,
	                        logic [15:0] idx, logic [7:0] val);
		int unsigned gap_pct;
		gap_pct = (stim_mode == 0) ? 23 : (stim_mode == 1) ? 83 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		cs         <= sel;
		copi       <= din;
		load_index <= idx;
		load_data  <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (kind == OP_LOAD)
			written_map[idx] = 1'b1;
		else
			sel_run = sel ? sel_run + 1 : 0;
		stim_mode = (beats_sent < ITEMS / 3) ? 0 : (beats_sent < 2 * ITEMS / 3) ? 1 : 2;
	endtask

	// clock edge beat; the load fields are don't-care and get random values
	task automatic send_edge(logic sel, logic din);
		put_beat(OP_EDGE, sel, din, 16'($urandom), 8'($urandom));
	endtask

	// store load beat; cs and copi are don't-care
	task automatic send_load(logic [15:0] idx, logic [7:0] val);
		put_beat(OP_LOAD, 1'($urandom), 1'($urandom), idx, val);
	endtask

	// n selected edges carrying word[n-1:0], msb first
	task automatic shift_out(logic [31:0] word, int n);
		for (int i = n - 1; i >= 0; i--)
			send_edge(1'b1, word[i]);
	endtask

	// deselect, release 0xab, deselect, 32-bit command, read edges, deselect;
	// works from any phase, since the release bits either power
	// the device up or are flushed out of the command by the second deselect
	task automatic read_burst(logic [7:0] opcode, logic [23:0] addr,
	                          int unsigned nread, bit drop_on_addr);
		logic [31:0] cmd;
		logic [31:0] a;
		cmd = {opcode, addr};
		// every byte the read may touch inside the window is loaded first;
		// the bit index is never cleared, so allow for a part byte either side
		for (int k = 0; k < nread / 8 + 3; k++) begin
			a = {8'h00, addr} + k;
			if (a >= cur_base && a < cur_base + cur_len && !written_map[16'(a - cur_base)])
				send_load(16'(a - cur_base), 8'($urandom));
		end
		send_edge(1'b0, 1'($urandom));
		shift_out({24'h0, CMD_RELEASE}, 8);
		send_edge(1'b0, 1'($urandom));
		shift_out(cmd >> 1, 31);
		// deselect on the edge closing the address still gives the first bit
		send_edge(!drop_on_addr, cmd[0]);
		if (!drop_on_addr) begin
			repeat (nread)
				send_edge(1'b1, 1'($urandom));
			send_edge(1'b0, 1'($urandom));
		end
	endtask

	// random opcode that is not a read
	function automatic logic [7:0] bad_opcode();
		logic [7:0] c;
		c = 8'($urandom);
		while (c == CMD_READ)
			c = 8'($urandom);
		return c;
	endfunction

	// register writes only happen with the device idle
	task automatic program_window(logic [31:0] b, logic [31:0] l);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FLASH_BASE;
		cfg_wdata <= b[BASE_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_FLASH_LENGTH;
		cfg_wdata <= l[BASE_W-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_base  = {8'h00, b[BASE_W-1:0]};
		cur_len   = {15'h0000, l[LEN_W-1:0]};
	endtask

	// stop offering, wait for every outstanding beat, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	// receiver: random stalls per mode, plus one long hold-off once asked for
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) <
				              ((stim_mode == 0) ? 83 : (stim_mode == 1) ? 23 : 0));
			end
		end
	end

	// watchdog on cycles in which no beat moves on either channel
	initial begin
		stale = 0;
		while (stale < STALE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stale = 0;
			else
				stale++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [31:0] b;
		logic [31:0] l;
		logic [31:0] pick;
		int unsigned window_end;
		int unsigned r;

		// every input known from time zero, reset held low at the start
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_FLASH_BASE;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		op         = OP_EDGE;
		cs         = 1'b0;
		copi       = 1'b0;
		load_index = '0;
		load_data  = '0;
		beats_sent = 0;
		stim_mode  = 0;
		sel_run    = 0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		cur_base   = '0;
		cur_len    = '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int w = 0; w < WINDOWS; w++) begin
			if (w > 0)
				drain();
			// window settings: whole store at both ends of the address space,
			// empty window, small random windows, a random one
			case (w)
				0: begin b = 0;                             l = STORE_DEPTH; end
				1: begin b = 32'h00FF_FFFF;                 l = STORE_DEPTH; end
				2: begin b = 0;                             l = 0;           end
				3: begin b = $urandom_range(0, 24'hFFFFFF); l = $urandom_range(1, 64); end
				4: begin b = $urandom_range(0, 24'hFFFFFF); l = 1;           end
				default: begin
					b = $urandom_range(0, 24'hFFFFFF);
					l = $urandom_range(0, STORE_DEPTH);
				end
			endcase
			program_window(b, l);

			if (w == 0) begin
				// directed: extreme loads, read from window start, run off the
				// window end, deselect on the address edge, outside reads, bad opcode
				send_load(16'h0000, 8'hFF);
				send_load(16'hFFFF, 8'h00);
				send_load(16'h5555, 8'hAA);
				send_load(16'hAAAA, 8'h55);
				read_burst(CMD_READ, 24'h000000, 16, 1'b0);
				read_burst(CMD_READ, 24'h00FFFE, 24, 1'b0);
				read_burst(CMD_READ, 24'h000001, 0, 1'b1);
				read_burst(CMD_READ, 24'h800000, 8, 1'b0);
				read_burst(CMD_READ, 24'hFFFFFF, 8, 1'b0);
				read_burst(8'h0B, 24'h000000, 4, 1'b0);
			end

			if (w == WINDOWS - 2) begin
				// long receiver hold-off while a read keeps the input busy
				hold_req = 1'b1;
				read_burst(CMD_READ, cur_base[23:0], 24, 1'b0);
			end

			// running total, so directed beats and overshoot count towards it
			window_end = (w + 1) * ITEMS / WINDOWS;
			while (beats_sent < window_end) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// well-formed read, address mostly inside or near the window
					case ($urandom_range(0, 3))
						0: pick = cur_base + ((cur_len != 0) ? $urandom_range(0, cur_len - 1) : 0);
						1: pick = cur_base + cur_len - $urandom_range(1, 3);
						2: pick = $urandom;
						default: pick = cur_base + $urandom_range(0, 7);
					endcase
					if ($urandom_range(0, 7) == 0)
						read_burst(CMD_READ, pick[23:0], 0, 1'b1);
					else
						read_burst(CMD_READ, pick[23:0], $urandom_range(0, 24), 1'b0);
				end else if (r < 75) begin
					// broken sequences, none of which can start a read
					case ($urandom_range(0, 3))
						0: begin
							// wrong release code
							send_edge(1'b0, 1'($urandom));
							l = {24'h0, 8'($urandom)};
							while (l[7:0] == CMD_RELEASE)
								l = {24'h0, 8'($urandom)};
							shift_out(l, 8);
							send_edge(1'b0, 1'($urandom));
							shift_out($urandom, 20);
							send_edge(1'b0, 1'($urandom));
						end
						1: read_burst(bad_opcode(), 24'($urandom), $urandom_range(0, 24), 1'b0);
						2: begin
							// command cut short by a deselect
							send_edge(1'b0, 1'($urandom));
							shift_out({24'h0, CMD_RELEASE}, 8);
							send_edge(1'b0, 1'($urandom));
							shift_out({CMD_READ, 24'($urandom)} >> 2, $urandom_range(1, 30));
							send_edge(1'b0, 1'($urandom));
						end
						default: begin
							// no deselect after the release
							send_edge(1'b0, 1'($urandom));
							shift_out({24'h0, CMD_RELEASE}, 8);
							shift_out({bad_opcode(), 24'($urandom)}, 32);
							send_edge(1'b0, 1'($urandom));
						end
					endcase
				end else if (r < 97) begin
					// noise: short random select runs and loads anywhere in the store
					repeat ($urandom_range(4, 24)) begin
						if ($urandom_range(0, 4) == 0)
							send_load(16'($urandom), 8'($urandom));
						else
							send_edge((sel_run >= MAX_SEL_RUN) ? 1'b0 : 1'($urandom),
							          1'($urandom));
					end
				end else begin
					// long select run of ones so the edge counter wraps
					send_edge(1'b0, 1'($urandom));
					repeat ($urandom_range(260, 300))
						send_edge(1'b1, 1'b1);
					send_edge(1'b0, 1'($urandom));
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule : spi_flash_read_responder_tb
